FILE: rtl/core/opi_pkg.sv
// ----------------------------------------------------------------------------
// opi_pkg
// Shared constants, types and tables for the omni pose integrator.
// ----------------------------------------------------------------------------
package opi_pkg;

  // Rotation stages run per tick, capped at the arctangent table depth
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned ATAN_DEPTH    = 32;
  localparam int unsigned STAGE_CNT     =
      (CORDIC_STAGES < ATAN_DEPTH) ? CORDIC_STAGES : ATAN_DEPTH;
  localparam int unsigned CNT_W         = $clog2(STAGE_CNT);
  localparam int unsigned STAGE_IDX_W   = $clog2(ATAN_DEPTH);

  // Datapath widths: rotated vector in 2^-32 m, angle in 2^-32 turn
  localparam int unsigned XW     = 42;
  localparam int unsigned ZW     = 34;
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // 1 / CORDIC gain in 2^-32 units
  localparam logic [31:0] KINV = 32'h9B74EDA8;

  localparam logic [31:0] ATAN_TURN [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // Configuration register indexes (byte address = 4 * index)
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_START_X       = 2'd0;
  localparam logic [1:0] REG_START_Y       = 2'd1;
  localparam logic [1:0] REG_START_HEADING = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_DX,
    OP_MUL_WX,
    OP_MUL_DY,
    OP_MUL_WY,
    OP_MUL_DH,
    OP_ROT,
    OP_COMMIT
  } opi_op_e;

  typedef struct packed {
    opi_op_e                 op;
    logic [STAGE_IDX_W-1:0]  stage;
  } opi_cmd_t;

endpackage

FILE: rtl/core/opi_if.sv
// ----------------------------------------------------------------------------
// opi_if
// Valid/ready channels for tick words in and pose words out.
// ----------------------------------------------------------------------------
interface opi_tick_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [15:0] vel_forward;
  logic signed [15:0] vel_lateral;
  logic signed [23:0] turn_rate;
  logic        [15:0] tick_period;

  modport source (output valid, restart, vel_forward, vel_lateral, turn_rate,
                  tick_period, input ready);
  modport sink   (input valid, restart, vel_forward, vel_lateral, turn_rate,
                  tick_period, output ready);
endinterface

interface opi_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

FILE: rtl/core/opi_ctrl.sv
// ----------------------------------------------------------------------------
// opi_ctrl
// Sequencer: multiply steps, CORDIC iterations, commit and output handshake.
// ----------------------------------------------------------------------------
module opi_ctrl import opi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     tick_valid_i,
  output logic     tick_ready_o,
  output logic     pose_valid_o,
  input  logic     pose_ready_i,
  output opi_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DX   = 3'd1;
  localparam logic [2:0] S_WX   = 3'd2;
  localparam logic [2:0] S_DY   = 3'd3;
  localparam logic [2:0] S_WY   = 3'd4;
  localparam logic [2:0] S_DH   = 3'd5;
  localparam logic [2:0] S_ROT  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] stage_q, stage_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    stage_d      = stage_q;
    out_valid_d  = out_valid_q && !pose_ready_i;
    tick_ready_o = 1'b0;
    cmd_o.op     = OP_IDLE;
    cmd_o.stage  = STAGE_IDX_W'(stage_q);
    unique case (state_q)
      S_IDLE: begin
        tick_ready_o = 1'b1;
        if (tick_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DX;
        end
      end
      S_DX: begin
        cmd_o.op = OP_MUL_DX;
        state_d  = S_WX;
      end
      S_WX: begin
        cmd_o.op = OP_MUL_WX;
        state_d  = S_DY;
      end
      S_DY: begin
        cmd_o.op = OP_MUL_DY;
        state_d  = S_WY;
      end
      S_WY: begin
        cmd_o.op = OP_MUL_WY;
        state_d  = S_DH;
      end
      S_DH: begin
        cmd_o.op = OP_MUL_DH;
        stage_d  = '0;
        state_d  = S_ROT;
      end
      S_ROT: begin
        cmd_o.op = OP_ROT;
        if (stage_q == CNT_W'(STAGE_CNT - 1)) begin
          state_d = S_DONE;
        end else begin
          stage_d = stage_q + 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || pose_ready_i) begin
          cmd_o.op    = OP_COMMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign pose_valid_o = out_valid_q;

endmodule

FILE: rtl/core/opi_datapath.sv
// ----------------------------------------------------------------------------
// opi_datapath
// Shared multiplier, CORDIC rotator and pose registers.
// ----------------------------------------------------------------------------
module opi_datapath import opi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  opi_cmd_t           cmd_i,
  input  logic               restart_i,
  input  logic signed [15:0] vel_forward_i,
  input  logic signed [15:0] vel_lateral_i,
  input  logic signed [23:0] turn_rate_i,
  input  logic        [15:0] tick_period_i,
  input  logic        [31:0] start_x_i,
  input  logic        [31:0] start_y_i,
  input  logic        [15:0] start_heading_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic        [15:0] heading_o
);

  logic               restart_q;
  logic signed [15:0] vf_q, vl_q;
  logic signed [23:0] wr_q;
  logic        [15:0] tp_q;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [XW-1:0]     x_q, y_q, fix_v, fix_neg;
  logic signed [XW-1:0]     sx, sy, rnd_x, rnd_y, sh_x, sh_y;
  logic signed [ZW-1:0]     z_q, z_init, atan_v;
  logic                     rot_neg, z_pos;
  logic        [15:0]       h_adj;
  logic        [31:0]       dh_sum;

  logic        [31:0] pose_x_q, pose_y_q;
  logic        [15:0] pose_h_q;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MUL_DX: begin
        mul_a = {{(MUL_W-16){vf_q[15]}}, vf_q};
        mul_b = {{(MUL_W-16){1'b0}}, tp_q};
      end
      OP_MUL_DY: begin
        mul_a = {{(MUL_W-16){vl_q[15]}}, vl_q};
        mul_b = {{(MUL_W-16){1'b0}}, tp_q};
      end
      OP_MUL_WX, OP_MUL_WY: begin
        mul_a = {prod_q[31], prod_q[31:0]};
        mul_b = {1'b0, KINV};
      end
      OP_MUL_DH: begin
        mul_a = {{(MUL_W-24){wr_q[23]}}, wr_q};
        mul_b = {{(MUL_W-16){1'b0}}, tp_q};
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Fold headings in the back half-turn onto the front half, negating the vector
  assign rot_neg = pose_h_q[15] ^ pose_h_q[14];
  assign h_adj   = pose_h_q ^ {rot_neg, 15'b0};
  assign z_init  = {{(ZW-32){h_adj[15]}}, h_adj, 16'h0000};

  assign fix_v   = prod_q[PROD_W-1:24];
  assign fix_neg = rot_neg ? -fix_v : fix_v;

  assign sx     = x_q >>> cmd_i.stage;
  assign sy     = y_q >>> cmd_i.stage;
  assign z_pos  = !z_q[ZW-1];
  assign atan_v = {{(ZW-32){1'b0}}, ATAN_TURN[cmd_i.stage]};

  assign rnd_x  = x_q + XW'(32768);
  assign rnd_y  = y_q + XW'(32768);
  assign sh_x   = rnd_x >>> 16;
  assign sh_y   = rnd_y >>> 16;
  assign dh_sum = prod_q[31:0] + 32'h0000_8000;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        restart_q <= restart_i;
        vf_q      <= vel_forward_i;
        vl_q      <= vel_lateral_i;
        wr_q      <= turn_rate_i;
        tp_q      <= tick_period_i;
      end
      OP_MUL_DX, OP_MUL_WX, OP_MUL_WY: prod_q <= prod_d;
      OP_MUL_DY: begin
        x_q    <= fix_neg;
        prod_q <= prod_d;
      end
      OP_MUL_DH: begin
        y_q    <= fix_neg;
        z_q    <= z_init;
        prod_q <= prod_d;
      end
      OP_ROT: begin
        if (z_pos) begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + atan_v;
        end
      end
      default: ;
    endcase
  end

  // Pose state doubles as the output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q <= '0;
      pose_y_q <= '0;
      pose_h_q <= '0;
    end else if (cmd_i.op == OP_COMMIT) begin
      if (restart_q) begin
        pose_x_q <= start_x_i;
        pose_y_q <= start_y_i;
        pose_h_q <= start_heading_i;
      end else begin
        pose_x_q <= pose_x_q + sh_x[31:0];
        pose_y_q <= pose_y_q + sh_y[31:0];
        pose_h_q <= pose_h_q + dh_sum[31:16];
      end
    end
  end

  assign pos_x_o   = pose_x_q;
  assign pos_y_o   = pose_y_q;
  assign heading_o = pose_h_q;

endmodule

FILE: rtl/core/omni_pose_integrator_top.sv
// ----------------------------------------------------------------------------
// omni_pose_integrator_top
// Dead-reckoning pose integrator for a holonomic base.
//
//   channel  dir  handshake          word
//   tick_i   in   valid/ready        restart, velocities, turn rate, period
//   pose_o   out  valid/ready        pos_x, pos_y, heading
//   apb      in   psel/penable       start_x, start_y, start_heading
//
// A tick goes from acceptance to the pose word in order: five passes through the
// one shared 33x33 multiplier, one CORDIC iteration per cycle, then a commit.
// A new tick is taken once the previous one has committed, even while its
// pose word still waits on pose_o. Commit stalls while the word is not taken.
// Reset clears the pose and start registers to zero.
// ----------------------------------------------------------------------------
module omni_pose_integrator_top import opi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  opi_tick_if.sink           tick_i,
  opi_pose_if.source         pose_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] start_x_q, start_y_q;
  logic [15:0] start_h_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;
  opi_cmd_t    cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      start_h_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_X:       start_x_q <= pwdata;
        REG_START_Y:       start_y_q <= pwdata;
        REG_START_HEADING: start_h_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_X:       prdata = start_x_q;
      REG_START_Y:       prdata = start_y_q;
      REG_START_HEADING: prdata = {16'h0000, start_h_q};
      default:           prdata = '0;
    endcase
  end

  opi_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (tick_i.valid),
    .tick_ready_o (tick_i.ready),
    .pose_valid_o (pose_o.valid),
    .pose_ready_i (pose_o.ready),
    .cmd_o        (cmd)
  );

  opi_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .restart_i       (tick_i.restart),
    .vel_forward_i   (tick_i.vel_forward),
    .vel_lateral_i   (tick_i.vel_lateral),
    .turn_rate_i     (tick_i.turn_rate),
    .tick_period_i   (tick_i.tick_period),
    .start_x_i       (start_x_q),
    .start_y_i       (start_y_q),
    .start_heading_i (start_h_q),
    .pos_x_o         (pose_o.pos_x),
    .pos_y_o         (pose_o.pos_y),
    .heading_o       (pose_o.heading)
  );

endmodule

FILE: rtl/core/opi_checker.sv
// ----------------------------------------------------------------------------
// opi_checker
// Port-level checks on tick and pose handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module opi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic tick_valid,
  input logic tick_ready,
  input logic pose_valid,
  input logic pose_ready
);

  logic tick_acc;
  assign tick_acc = tick_valid && tick_ready;

  // a pending pose word is not dropped
  a_pose_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_valid && !pose_ready |=> pose_valid)
    else $error("pose word dropped while stalled");

  // one tick at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> !tick_ready ##1 !tick_ready)
    else $error("tick taken while previous tick in progress");

  // no pose word appears directly after a tick is taken
  a_no_early_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> !$rose(pose_valid))
    else $error("pose word too early after tick");

  // a new pose word only follows a busy cycle
  a_pose_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pose_valid) |-> !$past(tick_ready))
    else $error("pose word without work in progress");

endmodule

bind omni_pose_integrator_top opi_checker u_opi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .tick_valid (tick_i.valid),
  .tick_ready (tick_i.ready),
  .pose_valid (pose_o.valid),
  .pose_ready (pose_o.ready)
);

FILE: bench/tb_omni_pose_integrator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_omni_pose_integrator_top
// Self-checking bench for the omni pose integrator. Tick words go in through a
// queue-fed driver. A local dead-reckoning model (CORDIC rotation,
// Q16.16 wrap, binary-angle heading) predicts each pose word, and the monitor
// compares every pose word against it. Start-pose registers are written
// through the APB port between phases.
// ----------------------------------------------------------------------------
module tb_omni_pose_integrator_top;
  import opi_pkg::*;

  localparam longint      ROT_GAIN_INV = 64'd2608131496;
  localparam logic [1:0]  REG_SPARE    = 2'd3;
  localparam int          HOLD_AT      = 80;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          RAND_PER_PH  = 146;
  localparam int          LIMIT_NS     = 5_000_000;

  // Arctangent steps in 2^-32 turn, truncated
  localparam logic [31:0] ATAN_STEP [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic               restart;
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_lateral;
    logic signed [23:0] turn_rate;
    logic        [15:0] tick_period;
  } tick_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
  } pose_t;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  opi_tick_if tick_if ();
  opi_pose_if pose_if ();

  omni_pose_integrator_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_if.sink),
    .pose_o  (pose_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state: start registers and the integrated pose
  logic [31:0] cfg_x = '0, cfg_y = '0;
  logic [15:0] cfg_h = '0;
  logic [31:0] est_x = '0, est_y = '0;
  logic [15:0] est_h = '0;

  tick_t tick_pend [$];
  pose_t pose_exp [$];
  tick_t tick_live;
  pose_t want;
  int    ticks_queued = 0;
  int    ticks_taken  = 0;
  int    mismatches   = 0;
  int    tick_gap     = 0;
  int    rdy_gap      = 0;
  logic  idle_on      = 1'b1;
  logic  hold_off     = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    tick_if.valid       = 1'b0;
    tick_if.restart     = 1'b0;
    tick_if.vel_forward = '0;
    tick_if.vel_lateral = '0;
    tick_if.turn_rate   = '0;
    tick_if.tick_period = '0;
    pose_if.ready       = 1'b0;
  end

  // Advance the pose by one tick and return the pose word it reports
  function automatic pose_t integrate_tick(tick_t t);
    longint      rx, ry, z, sx, sy, dx, dy, dh;
    logic [31:0] ang;
    pose_t       p;
    if (t.restart) begin
      est_x = cfg_x;
      est_y = cfg_y;
      est_h = cfg_h;
    end else if (t.vel_forward != 0 || t.vel_lateral != 0 || t.turn_rate != 0) begin
      rx = (longint'(t.vel_forward) * longint'(t.tick_period) * ROT_GAIN_INV) >>> 24;
      ry = (longint'(t.vel_lateral) * longint'(t.tick_period) * ROT_GAIN_INV) >>> 24;
      ang = {est_h, 16'h0000};
      // fold the left half-plane onto the right one
      if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
        rx = -rx;
        ry = -ry;
        ang = ang + 32'h8000_0000;
      end
      z = longint'($signed(ang));
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        sx = rx >>> i;
        sy = ry >>> i;
        if (z >= 0) begin
          rx = rx - sy;
          ry = ry + sx;
          z  = z - longint'(ATAN_STEP[i]);
        end else begin
          rx = rx + sy;
          ry = ry - sx;
          z  = z + longint'(ATAN_STEP[i]);
        end
      end
      dx = (rx + 32768) >>> 16;
      dy = (ry + 32768) >>> 16;
      dh = (longint'(t.turn_rate) * longint'(t.tick_period) + 32768) >>> 16;
      est_x = est_x + dx[31:0];
      est_y = est_y + dy[31:0];
      est_h = est_h + dh[15:0];
    end
    p.pos_x   = est_x;
    p.pos_y   = est_y;
    p.heading = est_h;
    return p;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_tick(logic r, logic [15:0] vf, logic [15:0] vl,
                                    logic [23:0] tr, logic [15:0] tp);
    tick_t t;
    t.restart     = r;
    t.vel_forward = vf;
    t.vel_lateral = vl;
    t.turn_rate   = tr;
    t.tick_period = tp;
    tick_pend.push_back(t);
    ticks_queued++;
  endfunction

  function automatic void push_random_tick();
    int          r;
    logic [15:0] vf, vl, tp;
    logic [23:0] tr;
    r  = $urandom_range(0, 99);
    vf = 16'($urandom);
    vl = 16'($urandom);
    tr = 24'($urandom);
    tp = 16'($urandom);
    if (r < 4) begin
      push_tick(1'b1, vf, vl, tr, tp);
    end else if (r < 8) begin
      push_tick(1'b0, '0, '0, '0, tp);
    end else if (r < 22) begin
      // corners of the field ranges
      case ($urandom_range(0, 2))
        0: vf = 16'h7FFF;
        1: vf = 16'h8000;
        default: vf = '0;
      endcase
      case ($urandom_range(0, 2))
        0: vl = 16'h7FFF;
        1: vl = 16'h8000;
        default: vl = '0;
      endcase
      case ($urandom_range(0, 2))
        0: tr = 24'h7FFFFF;
        1: tr = 24'h800000;
        default: ;
      endcase
      if ($urandom_range(0, 1) == 0) tp = 16'hFFFF;
      push_tick(1'b0, vf, vl, tr, tp);
    end else begin
      push_tick(1'b0, vf, vl, tr, tp);
    end
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_X:       cfg_x = data;
      REG_START_Y:       cfg_y = data;
      REG_START_HEADING: cfg_h = data[15:0];
      default: ;
    endcase
  endtask

  task automatic apb_check(input logic [1:0] idx, input logic [31:0] data,
                           input logic [31:0] mask);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((prdata & mask) !== (data & mask)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d readback: expected %08h, got %08h", idx, data & mask,
                 prdata & mask);
    end
  endtask

  // Write the start pose, poke the unused slot, read back
  task automatic load_start(input logic [31:0] x, input logic [31:0] y,
                            input logic [15:0] h);
    apb_write(REG_START_X, x);
    apb_write(REG_START_Y, y);
    apb_write(REG_START_HEADING, {16'($urandom), h});
    apb_write(REG_SPARE, $urandom);
    apb_check(REG_START_X, cfg_x, 32'hFFFF_FFFF);
    apb_check(REG_START_Y, cfg_y, 32'hFFFF_FFFF);
    apb_check(REG_START_HEADING, {16'h0000, cfg_h}, 32'h0000_FFFF);
  endtask

  task automatic drain();
    while (tick_pend.size() != 0 || ticks_taken != ticks_queued || pose_exp.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver: offer queued tick words, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
      tick_gap = 0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        pose_exp.push_back(integrate_tick(tick_live));
        ticks_taken++;
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_gap != 0) begin
          tick_if.valid <= 1'b0;
          tick_gap--;
        end else if (tick_pend.size() != 0) begin
          tick_live = tick_pend.pop_front();
          tick_if.valid       <= 1'b1;
          tick_if.restart     <= tick_live.restart;
          tick_if.vel_forward <= tick_live.vel_forward;
          tick_if.vel_lateral <= tick_live.vel_lateral;
          tick_if.turn_rate   <= tick_live.turn_rate;
          tick_if.tick_period <= tick_live.tick_period;
          tick_gap = pick_gap();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take pose words and compare with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pose_if.ready <= 1'b0;
      rdy_gap = 0;
    end else begin
      if (pose_if.valid && pose_if.ready) begin
        if (pose_exp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose word with none pending: x %08h y %08h heading %04h",
                     pose_if.pos_x, pose_if.pos_y, pose_if.heading);
        end else begin
          want = pose_exp.pop_front();
          if (pose_if.pos_x !== want.pos_x || pose_if.pos_y !== want.pos_y ||
              pose_if.heading !== want.heading) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pose mismatch: exp x %08h y %08h h %04h, got x %08h y %08h h %04h",
                       want.pos_x, want.pos_y, want.heading,
                       pose_if.pos_x, pose_if.pos_y, pose_if.heading);
          end
        end
        rdy_gap = pick_gap();
      end else if (rdy_gap == 0 && $urandom_range(0, 15) == 0) begin
        rdy_gap = pick_gap();
      end
      if (hold_off || rdy_gap != 0) begin
        pose_if.ready <= 1'b0;
        if (rdy_gap != 0) rdy_gap--;
      end else begin
        pose_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall while the sender keeps offering
  initial begin
    while (ticks_taken < HOLD_AT) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("omni_pose_integrator_top test failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset start pose
    @(negedge clk_i);
    push_tick(1'b1, '0, '0, '0, '0);
    push_tick(1'b0, 16'h0100, '0, '0, 16'h8000);
    drain();

    load_start(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    @(negedge clk_i);
    push_tick(1'b1, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 16'hFFFF);
    push_tick(1'b0, '0, '0, '0, 16'hFFFF);
    push_tick(1'b0, 16'h7FFF, '0, '0, 16'hFFFF);
    push_tick(1'b0, 16'h8000, '0, '0, 16'hFFFF);
    push_tick(1'b0, '0, 16'h7FFF, '0, 16'hFFFF);
    push_tick(1'b0, '0, 16'h8000, '0, 16'hFFFF);
    push_tick(1'b0, '0, '0, 24'h7FFFFF, 16'hFFFF);
    push_tick(1'b0, '0, '0, 24'h800000, 16'hFFFF);
    push_tick(1'b0, 16'h7FFF, 16'h8000, 24'h7FFFFF, '0);
    push_tick(1'b0, 16'h8000, 16'h8000, 24'h800000, 16'hFFFF);
    push_tick(1'b0, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 16'hFFFF);
    push_tick(1'b0, '0, '0, 24'h000001, 16'h0001);
    push_tick(1'b1, '0, '0, '0, '0);
    // half-step rounding carries the heading across zero
    push_tick(1'b0, '0, '0, 24'h000001, 16'h8000);
    // quarter turns: visit every quadrant boundary with motion
    repeat (4) push_tick(1'b0, 16'h0100, 16'hFF80, 24'd16384, 16'hFFFF);
    push_tick(1'b0, 16'h0100, 16'h0040, 24'hFFC000, 16'hFFFF);
    push_tick(1'b0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'h0001);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_start($urandom, $urandom, 16'($urandom));
        1: load_start(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
        2: load_start(32'h0000_0000, 32'h0000_0000, 16'h4000);
        3: load_start($urandom, $urandom, 16'($urandom));
        default: load_start(32'hFFFF_FFFF, 32'h0000_0001, 16'hC000);
      endcase
      // no idling at all in one phase
      idle_on <= (ph != 1);
      @(negedge clk_i);
      push_tick(1'b1, 16'($urandom), 16'($urandom), 24'($urandom), 16'($urandom));
      repeat (RAND_PER_PH) push_random_tick();
      drain();
    end

    while (pose_exp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pose_exp.size() == 0) begin
      $display("omni_pose_integrator_top test passed");
    end else begin
      $display("omni_pose_integrator_top test failed");
    end
    $finish;
  end

endmodule
